@@ design/pdac_pkg.sv @@
// ----------------------------------------------------------------------------
// pdac_pkg
// Shared types, constants and helpers of the palette DAC with fade.
// ----------------------------------------------------------------------------
`default_nettype none

package pdac_pkg;

  localparam int unsigned PaletteEntries = 256;

  localparam int unsigned IndexW = 8;
  localparam int unsigned CompW  = 6;
  localparam int unsigned StepW  = 8;
  localparam int unsigned ProdW  = CompW + StepW;
  localparam int unsigned EntryW = 3 * CompW;
  localparam int unsigned PixelW = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  // quotient of the blend never exceeds the component range
  localparam int unsigned DivIters = CompW;

  localparam logic [7:0] Alpha = 8'hFF;

  localparam logic [CfgIdxW-1:0] CFG_FADE_ENABLE = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FADE_FIRST  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_FADE_LAST   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_FADE_RED    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_FADE_GREEN  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_FADE_BLUE   = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_FADE_STEPS  = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_FADE_STEP   = 3'd7;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  typedef struct packed {
    logic load;   // take the entry value and form the product
    logic iter;   // one restoring division step
    logic fade;   // apply the blend to this word
  } pdac_lane_ctrl_t;

  // 6 to 8 bit expansion: replicate the top bits into the bottom
  function automatic logic [7:0] widen6(input logic [CompW-1:0] v);
    widen6 = {v, v[CompW-1 -: 2]};
  endfunction

endpackage

`default_nettype wire

@@ design/pdac_ram.sv @@
// ----------------------------------------------------------------------------
// pdac_ram
// Generic single-port RAM, synchronous write, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pdac_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

@@ design/pdac_lane.sv @@
// ----------------------------------------------------------------------------
// pdac_lane
// One colour component: blend product and bit-serial restoring divide.
// ----------------------------------------------------------------------------
`default_nettype none

module pdac_lane
  import pdac_pkg::*;
(
  input  wire logic            clk_i,
  input  wire pdac_lane_ctrl_t ctrl_i,
  input  wire logic [CompW-1:0] value_i,
  input  wire logic [CompW-1:0] target_i,
  input  wire logic [StepW-1:0] step_i,
  input  wire logic [ProdW-1:0] divisor_i,
  output logic      [CompW-1:0] result_o
);

  logic [CompW-1:0] value_q;
  logic             neg_q;
  logic             fade_q;
  logic [ProdW-1:0] rem_q, rem_d;
  logic [CompW-1:0] quot_q, quot_d;
  logic [CompW-1:0] mag;
  logic             neg;

  always_comb begin
    neg = target_i < value_i;
    mag = neg ? (value_i - target_i) : (target_i - value_i);
    rem_d  = rem_q;
    quot_d = quot_q;
    if (ctrl_i.load) begin
      rem_d  = ProdW'(mag) * ProdW'(step_i);
      quot_d = '0;
    end else if (ctrl_i.iter) begin
      if (rem_q >= divisor_i) begin
        rem_d  = rem_q - divisor_i;
        quot_d = {quot_q[CompW-2:0], 1'b1};
      end else begin
        quot_d = {quot_q[CompW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (ctrl_i.load) begin
      value_q <= value_i;
      neg_q   <= neg;
      fade_q  <= ctrl_i.fade;
    end
  end

  // truncation toward zero: take the magnitude quotient and restore the sign
  always_comb begin
    if (!fade_q) begin
      result_o = value_q;
    end else if (neg_q) begin
      result_o = value_q - quot_q;
    end else begin
      result_o = value_q + quot_q;
    end
  end

endmodule

`default_nettype wire

@@ design/palette_dac_with_fade.sv @@
// ----------------------------------------------------------------------------
// palette_dac_with_fade
// Palette lookup with 6 to 8 bit expansion and a fade toward a target colour.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries mode, index and an RGB
// entry. A mode 0 word writes the palette entry in the cycle it is taken
// and gives no output; the next word is taken in the following cycle.
// A mode 1 word reads the palette, blends it toward the fade target when
// the index lies in the fade range, and gives one RGBA8888 word on the
// output channel (out_valid_o / out_stall_i). Pixels are handled one at a time:
// a pixel occupies the block through the palette read, the product cycle, the
// six-step bit-serial divide run in step by the three colour lanes, and the move
// into the output register.
// The finished word sits in an output register, so a new word is taken while
// it waits; a further pixel waits in its last step until that register is taken.
// Reset sets the fade registers to their defaults and marks every palette entry
// as black through per-entry valid flags; no clearing pass is needed.
// Configuration is written through cfg_we_i / cfg_index_i / cfg_data_i when idle;
// the user must keep to this, as the block itself does not enforce it.
`default_nettype none

module palette_dac_with_fade
  import pdac_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = PaletteEntries
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                mode_i,
  input  wire logic [IndexW-1:0]   index_i,
  input  wire logic [CompW-1:0]    red_i,
  input  wire logic [CompW-1:0]    green_i,
  input  wire logic [CompW-1:0]    blue_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [PixelW-1:0]        pixel_rgba_o
);

  localparam int unsigned AddrW = $clog2(PALETTE_ENTRIES);
  localparam int unsigned CntW  = $clog2(DivIters);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  // configuration
  logic             fade_enable_q;
  logic [7:0]       fade_first_q, fade_last_q;
  logic [CompW-1:0] fade_red_q, fade_green_q, fade_blue_q;
  logic [StepW-1:0] fade_steps_q, fade_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_enable_q <= 1'b0;
      fade_first_q  <= 8'd0;
      fade_last_q   <= 8'd255;
      fade_red_q    <= '0;
      fade_green_q  <= '0;
      fade_blue_q   <= '0;
      fade_steps_q  <= 8'd1;
      fade_step_q   <= 8'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FADE_ENABLE: fade_enable_q <= cfg_data_i[0];
        CFG_FADE_FIRST:  fade_first_q  <= cfg_data_i;
        CFG_FADE_LAST:   fade_last_q   <= cfg_data_i;
        CFG_FADE_RED:    fade_red_q    <= cfg_data_i[CompW-1:0];
        CFG_FADE_GREEN:  fade_green_q  <= cfg_data_i[CompW-1:0];
        CFG_FADE_BLUE:   fade_blue_q   <= cfg_data_i[CompW-1:0];
        CFG_FADE_STEPS:  fade_steps_q  <= cfg_data_i;
        CFG_FADE_STEP:   fade_step_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control
  logic [1:0]            state_q, state_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  ent_ok_q;
  logic                  fade_hit_q;
  logic [ProdW-1:0]      divisor_q, divisor_d;
  logic                  out_valid_q;
  logic [PixelW-1:0]     pixel_q;
  logic [PALETTE_ENTRIES-1:0] valid_q;

  logic                  in_accept;
  logic                  in_range;
  logic                  fade_hit;
  logic [AddrW-1:0]      addr;
  logic                  ram_we, ram_re;
  logic [EntryW-1:0]     ram_rdata;
  logic [EntryW-1:0]     entry;
  logic [StepW-1:0]      step_sat;
  logic                  out_load;
  pdac_lane_ctrl_t       lane_ctrl;
  logic [CompW-1:0]      red_res, green_res, blue_res;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_range   = {1'b0, index_i} < (IndexW + 1)'(PALETTE_ENTRIES);
  assign addr       = index_i[AddrW-1:0];
  assign ram_we     = in_accept && (mode_i == MODE_WRITE) && in_range;
  assign ram_re     = in_accept && (mode_i == MODE_PIXEL);
  assign fade_hit   = fade_enable_q && (index_i >= fade_first_q) &&
                      (index_i <= fade_last_q) && (fade_steps_q != '0);
  assign step_sat   = (fade_step_q > fade_steps_q) ? fade_steps_q : fade_step_q;
  assign entry      = ent_ok_q ? ram_rdata : '0;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  pdac_ram #(
    .WIDTH (EntryW),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (addr),
    .wdata_i ({red_i, green_i, blue_i}),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    divisor_d = divisor_q;
    lane_ctrl = '{load: 1'b0, iter: 1'b0, fade: fade_hit_q};
    case (state_q)
      S_IDLE: begin
        if (ram_re) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        lane_ctrl.load = 1'b1;
        divisor_d      = {fade_steps_q, {(ProdW - StepW){1'b0}}} >> 1;
        cnt_d          = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        lane_ctrl.iter = 1'b1;
        divisor_d      = divisor_q >> 1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivIters - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (ram_we) begin
        valid_q[addr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    divisor_q <= divisor_d;
    if (ram_re) begin
      // out-of-range pixels read as black
      ent_ok_q   <= in_range && valid_q[addr];
      fade_hit_q <= fade_hit;
    end
    if (out_load) begin
      pixel_q <= {widen6(red_res), widen6(green_res), widen6(blue_res), Alpha};
    end
  end

  pdac_lane u_red (
    .clk_i     (clk_i),
    .ctrl_i    (lane_ctrl),
    .value_i   (entry[3*CompW-1 -: CompW]),
    .target_i  (fade_red_q),
    .step_i    (step_sat),
    .divisor_i (divisor_q),
    .result_o  (red_res)
  );

  pdac_lane u_green (
    .clk_i     (clk_i),
    .ctrl_i    (lane_ctrl),
    .value_i   (entry[2*CompW-1 -: CompW]),
    .target_i  (fade_green_q),
    .step_i    (step_sat),
    .divisor_i (divisor_q),
    .result_o  (green_res)
  );

  pdac_lane u_blue (
    .clk_i     (clk_i),
    .ctrl_i    (lane_ctrl),
    .value_i   (entry[CompW-1:0]),
    .target_i  (fade_blue_q),
    .step_i    (step_sat),
    .divisor_i (divisor_q),
    .result_o  (blue_res)
  );

  assign out_valid_o  = out_valid_q;
  assign pixel_rgba_o = pixel_q;

`ifndef SYNTH
  a_pixel_starts_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && mode_i == MODE_PIXEL) |=> (state_q == S_READ))
    else $error("pixel word did not start a palette read");

  a_write_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && mode_i == MODE_WRITE) |=> (state_q == S_IDLE))
    else $error("palette write left the block busy");

  a_div_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (cnt_q < CntW'(DivIters)))
    else $error("divide step count overran");

  a_last_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_q == CntW'(DivIters - 1)) |->
    (divisor_q == ProdW'(fade_steps_q)))
    else $error("divisor misaligned at final divide step");

  a_done_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !out_valid_q) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished pixel not moved to the output register");
`endif

endmodule

`default_nettype wire
